// ===== rtl/core/nrc_pkg.sv =====
// nrc_pkg: types and constants shared by the normalized RGB convolution block.
// No dependencies.
`timescale 1ns / 1ps
package nrc_pkg;
   localparam int MAX_KERNEL = 7;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int KS_W = 3;
   localparam int FW_W = 11;
   localparam int POS_W = 10;
   localparam int IDX_W = 6;
   localparam int KV_W = 16;
   localparam int PIX_W = 8;

   localparam logic REQ_WEIGHT = 1'b0;
   localparam logic REQ_PIXEL  = 1'b1;

   localparam logic [1:0] REG_KSIZE  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic [0:0]       req_type;
      logic [IDX_W-1:0] kernel_index;
      logic [KV_W-1:0]  kernel_value;
      logic [PIX_W-1:0] pixel_red;
      logic [PIX_W-1:0] pixel_green;
      logic [PIX_W-1:0] pixel_blue;
   } req_type_t_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_end;
      logic             norm_zero;
   } rsp_type;
endpackage

// ===== rtl/core/nrc_if.sv =====
// nrc_if: valid/ready channel interfaces for requests and responses.
// Depends on nrc_pkg.
`timescale 1ns / 1ps
interface nrc_req_if;
   import nrc_pkg::*;
   logic valid;
   logic ready;
   req_type_t_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface nrc_rsp_if;
   import nrc_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/normalized_rgb_convolution.sv =====
// normalized_rgb_convolution: top level, line memory, serial MAC and divider.
// Depends on nrc_pkg and nrc_if.
`timescale 1ns / 1ps
//  channel | dir | handshake
//  req     | in  | valid/ready, req_ prefix
//  rsp     | out | valid/ready, rsp_ prefix
//  csr     | in  | APB write/read, pready tied high
// A pixel that completes a window shows its response after one line-memory read
// per window tap through the shared MAC, then a 24-step restoring divider; the
// block takes the next transaction in the same cycle the response shows.
// Weight writes and CSR writes re-sum the kernel. Window pixels that complete
// no output pass through S_SKIP. Reset is synchronous; a stalled response
// holds in the output register and the next result waits in S_OUT.
module normalized_rgb_convolution (
   input  logic        clock,
   input  logic        reset,
   nrc_req_if.sink     req,
   nrc_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nrc_pkg::*;

   localparam int KST = MAX_KERNEL * MAX_KERNEL;
   localparam int KI_W = $clog2(KST);
   localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH;
   localparam int LA_W = $clog2(LDEPTH);
   localparam int RM_W = $clog2(MAX_KERNEL + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int ACC_W = 40;
   localparam int SUM_W = 22;
   localparam int DIV_STEPS = 24;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SUM = 6'b000010, S_MAC = 6'b000100,
      S_DIV = 6'b001000, S_OUT = 6'b010000, S_SKIP = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [KS_W-1:0] ksize_ff;
   logic [FW_W-1:0] fw_ff, fh_ff;
   logic [KV_W-1:0] kmem [KST];
   logic [KST-1:0]  kvalid_ff;
   logic [23:0]     lmem [LDEPTH];
   logic [23:0]     lrd_ff;
   logic [KV_W-1:0] krd_ff;
   logic [SUM_W-1:0] wsum_ff;
   logic [POS_W-1:0] row_ff, col_ff;
   logic [3:0] kr_ff, kc_ff;
   logic       rdv_ff;
   logic [ACC_W-1:0] acc_ff [3];
   logic [ACC_W-1:0] rem_ff [3];
   logic [7:0]       q_ff [3];
   logic [4:0]       dcnt_ff;
   rsp_type          out_ff;
   logic             oval_ff;
   logic [POS_W-1:0] r0_ff, c0_ff;
   logic             fend_ff;

   logic [3:0] k;
   logic [FW_W-1:0] w, h;
   always_comb begin
      k = (ksize_ff == '0) ? 4'd1 :
          ({1'b0, ksize_ff} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : {1'b0, ksize_ff};
      w = (fw_ff == '0) ? FW_W'(1) : (fw_ff > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_ff;
      h = (fh_ff == '0) ? FW_W'(1) : (fh_ff > FW_W'(MAX_HEIGHT)) ? FW_W'(MAX_HEIGHT) : fh_ff;
   end

   // csr
   logic cwr;
   assign cwr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_KSIZE:  csr_prdata = {29'd0, ksize_ff};
         REG_WIDTH:  csr_prdata = {21'd0, fw_ff};
         REG_HEIGHT: csr_prdata = {21'd0, fh_ff};
         default:    csr_prdata = '0;
      endcase
   end

   logic acc_req, is_pix, oload;
   assign req.ready = (state_ff == S_IDLE);
   assign acc_req = req.valid && req.ready;
   assign is_pix = req.data.req_type == REQ_PIXEL;
   assign oload = (state_ff == S_OUT) && (!oval_ff || rsp.ready);

   // position of the accepted pixel
   logic [CW-1:0] colc;
   logic [RM_W-1:0] rmod_ff;
   logic [RM_W-1:0] rmod_px_ff;
   logic emit;
   always_comb begin
      colc = ({1'b0, col_ff} >= 11'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(col_ff);
      emit = ({1'b0, row_ff} >= 11'(k) - 11'd1) && (11'(colc) >= 11'(k) - 11'd1)
             && ({1'b0, row_ff} < h) && (11'(colc) < w);
   end

   logic [LA_W-1:0] waddr, raddr;
   logic [3:0] rrow;
   logic [4:0] rrs;
   always_comb begin
      waddr = LA_W'(rmod_ff) * LA_W'(MAX_WIDTH) + LA_W'(colc);
      rrs = 5'(rmod_px_ff) + 5'(MAX_KERNEL) + 5'(kr_ff) + 5'd1 - 5'(k);
      rrow = (rrs >= 5'(2*MAX_KERNEL)) ? 4'(rrs - 5'(2*MAX_KERNEL)) :
             (rrs >= 5'(MAX_KERNEL)) ? 4'(rrs - 5'(MAX_KERNEL)) : 4'(rrs);
      raddr = LA_W'(rrow) * LA_W'(MAX_WIDTH) + LA_W'(c0_ff) + LA_W'(kc_ff);
   end

   logic [KI_W-1:0] kaddr;
   assign kaddr = KI_W'(kr_ff * k + {2'd0, kc_ff});
   logic last_tap;
   assign last_tap = (kr_ff == k - 4'd1) && (kc_ff == k - 4'd1);

   always_ff @(posedge clock) begin
      if (acc_req && is_pix) lmem[waddr] <= {req.data.pixel_blue, req.data.pixel_green,
                                             req.data.pixel_red};
      lrd_ff <= lmem[raddr];
      if (acc_req && !is_pix && req.data.kernel_index < IDX_W'(KST))
         kmem[KI_W'(req.data.kernel_index)] <= req.data.kernel_value;
      krd_ff <= kvalid_ff[kaddr] ? kmem[kaddr] : '0;
   end

   logic [ACC_W-1:0] dnum [3];
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (cwr) state_in = S_SUM;
                 else if (acc_req) state_in = !is_pix ? S_SUM : emit ? S_MAC : S_SKIP;
         S_SUM:  if (rdv_ff && kr_ff == 4'd0 && kc_ff == 4'd0) state_in = S_IDLE;
         S_MAC:  if (rdv_ff && kr_ff == 4'd0 && kc_ff == 4'd0) state_in = S_DIV;
         S_DIV:  if (dcnt_ff == 5'(DIV_STEPS - 1)) state_in = S_OUT;
         S_OUT:  if (!oval_ff || rsp.ready) state_in = S_IDLE;
         S_SKIP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic [SUM_W-1:0] sum_acc_ff;
   logic done_taps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ksize_ff <= 3'd3;
         fw_ff <= 11'd1024; fh_ff <= 11'd1024;
         kvalid_ff <= '0; wsum_ff <= '0; row_ff <= '0; col_ff <= '0;
         rmod_ff <= '0; kr_ff <= '0; kc_ff <= '0; rdv_ff <= 1'b0; oval_ff <= 1'b0;
         done_taps_ff <= 1'b0; dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (oload) oval_ff <= 1'b1;
         else if (rsp.valid && rsp.ready) oval_ff <= 1'b0;
         if (cwr) begin
            unique case (csr_paddr[3:2])
               REG_KSIZE:  ksize_ff <= csr_pwdata[KS_W-1:0];
               REG_WIDTH:  fw_ff <= csr_pwdata[FW_W-1:0];
               REG_HEIGHT: fh_ff <= csr_pwdata[FW_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && (cwr || acc_req)) begin
            kr_ff <= '0; kc_ff <= '0; rdv_ff <= 1'b0; done_taps_ff <= 1'b0;
            sum_acc_ff <= '0;
            for (int c = 0; c < 3; c++) acc_ff[c] <= '0;
         end
         if (acc_req && !is_pix) begin
            if (req.data.kernel_index < IDX_W'(KST))
               kvalid_ff[KI_W'(req.data.kernel_index)] <= 1'b1;
            row_ff <= '0; col_ff <= '0; rmod_ff <= '0;
         end
         if (acc_req && is_pix) begin
            r0_ff <= row_ff - POS_W'(k - 4'd1);
            c0_ff <= POS_W'(colc) - POS_W'(k - 4'd1);
            rmod_px_ff <= rmod_ff;
            fend_ff <= ({1'b0, row_ff} == h - 11'd1) && (11'(colc) == w - 11'd1);
            if (11'(colc) + 11'd1 >= w) begin
               col_ff <= '0;
               if ({1'b0, row_ff} + 11'd1 >= h) begin
                  row_ff <= '0; rmod_ff <= '0;
               end else begin
                  row_ff <= row_ff + POS_W'(1);
                  rmod_ff <= (rmod_ff == RM_W'(MAX_KERNEL - 1)) ? '0 : rmod_ff + RM_W'(1);
               end
            end else col_ff <= POS_W'(colc) + POS_W'(1);
         end
         if (state_ff == S_SUM || state_ff == S_MAC) begin
            if (!done_taps_ff) begin
               rdv_ff <= 1'b1;
               if (last_tap) begin
                  kr_ff <= '0; kc_ff <= '0; done_taps_ff <= 1'b1;
               end else if (kc_ff == k - 4'd1) begin
                  kc_ff <= '0; kr_ff <= kr_ff + 4'd1;
               end else kc_ff <= kc_ff + 4'd1;
            end else rdv_ff <= 1'b0;
            if (rdv_ff) begin
               sum_acc_ff <= sum_acc_ff + SUM_W'(krd_ff);
               for (int c = 0; c < 3; c++)
                  acc_ff[c] <= acc_ff[c] + ACC_W'(lrd_ff[8*c +: 8] * krd_ff);
            end
            if (state_ff == S_SUM && state_in == S_IDLE)
               wsum_ff <= sum_acc_ff + SUM_W'(krd_ff);
         end
         if (state_ff == S_MAC && state_in == S_DIV) begin
            dcnt_ff <= '0;
            for (int c = 0; c < 3; c++) begin
               rem_ff[c] <= acc_ff[c] + ACC_W'(lrd_ff[8*c +: 8] * krd_ff);
               q_ff[c] <= '0;
            end
         end
         if (state_ff == S_DIV) begin
            dcnt_ff <= dcnt_ff + 5'd1;
            for (int c = 0; c < 3; c++) begin
               q_ff[c] <= {q_ff[c][6:0], dnum[c] <= rem_ff[c]};
               if (dnum[c] <= rem_ff[c]) rem_ff[c] <= rem_ff[c] - dnum[c];
            end
         end
      end
   end

   // restoring division, quotient bit 23-dcnt; only low 8 bits are kept
   always_comb begin
      for (int c = 0; c < 3; c++)
         dnum[c] = (wsum_ff == '0) ? {ACC_W{1'b1}} :
                   ACC_W'({18'd0, wsum_ff} << (5'(DIV_STEPS - 1) - dcnt_ff));
   end

   always_ff @(posedge clock) begin
      if (oload) begin
         out_ff.out_red   <= (wsum_ff == '0) ? '0 : q_ff[0];
         out_ff.out_green <= (wsum_ff == '0) ? '0 : q_ff[1];
         out_ff.out_blue  <= (wsum_ff == '0) ? '0 : q_ff[2];
         out_ff.out_row   <= r0_ff;
         out_ff.out_col   <= c0_ff;
         out_ff.frame_end <= fend_ff;
         out_ff.norm_zero <= wsum_ff == '0;
      end
   end

   assign rsp.valid = oval_ff;
   assign rsp.data = out_ff;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && oval_ff && !rsp.ready |=> state_ff == S_OUT)
      else $error("response overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response dropped");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.norm_zero |-> rsp.data.out_red == '0)
      else $error("zero sum output");
endmodule
